// ===== rtl/core/gdad_pkg.sv =====
// ============================================================================
// Gregorian date add-days package
// Shared widths, calendar constants and month-length helpers for the
// date shifter and its channel interfaces.
// ============================================================================
`default_nettype none

package gdad_pkg;

    // Default values for the top-level parameters.
    localparam int MIN_YEAR_DEF    = 1900;
    localparam int MAX_YEAR_DEF    = 9999;
    localparam int OFFSET_BITS_DEF = 21;

    // Field widths.
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_IN_W = 14;
    localparam int YEAR_W    = 16;
    localparam int YMOD_W    = 9;

    // The leap-year pattern repeats every 400 years.
    localparam logic [YMOD_W-1:0] LEAP_CYCLE = 9'd400;
    localparam logic [YMOD_W-1:0] YMOD_LAST  = 9'd399;
    localparam logic [YMOD_W-1:0] YMOD_C100  = 9'd100;
    localparam logic [YMOD_W-1:0] YMOD_C200  = 9'd200;
    localparam logic [YMOD_W-1:0] YMOD_C300  = 9'd300;

    // Month codes.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;

    // Length of each month in a common year, January first.
    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Leap test on a year already reduced modulo 400.
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic leap;
        if (ymod == '0)
            leap = 1'b1;
        else if (ymod == YMOD_C100 || ymod == YMOD_C200 || ymod == YMOD_C300)
            leap = 1'b0;
        else
            leap = (ymod[1:0] == 2'b00);
        return leap;
    endfunction

    // Number of days in a month; codes outside 1..12 read as a long month.
    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   days;
        idx = month - MONTH_JAN;
        if (month == MONTH_FEB && leap)
            days = DAYS_FEB_LEAP;
        else if (month >= MONTH_JAN && month <= MONTH_DEC)
            days = MONTH_LEN[idx];
        else
            days = DAYS_LONG;
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gdad_req_if.sv =====
// ============================================================================
// Date shifter request channel
// Valid/ready channel that carries a start date and a signed day offset.
// ============================================================================
`default_nettype none

interface gdad_req_if
    import gdad_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
);

    logic                          valid;
    logic                          ready;
    logic [DAY_W-1:0]              start_day;
    logic [MONTH_W-1:0]            start_month;
    logic [YEAR_IN_W-1:0]          start_year;
    logic signed [OFFSET_BITS-1:0] day_offset;

    modport source (
        output valid,
        output start_day,
        output start_month,
        output start_year,
        output day_offset,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_day,
        input  start_month,
        input  start_year,
        input  day_offset,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/core/gdad_rsp_if.sv =====
// ============================================================================
// Date shifter result channel
// Valid/ready channel that carries the shifted date and its status flags.
// ============================================================================
`default_nettype none

interface gdad_rsp_if
    import gdad_pkg::*;
;

    logic                 valid;
    logic                 ready;
    logic [DAY_W-1:0]     result_day;
    logic [MONTH_W-1:0]   result_month;
    logic [YEAR_IN_W-1:0] result_year;
    logic                 start_valid;
    logic                 hit_floor;
    logic                 hit_ceiling;

    modport source (
        output valid,
        output result_day,
        output result_month,
        output result_year,
        output start_valid,
        output hit_floor,
        output hit_ceiling,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_day,
        input  result_month,
        input  result_year,
        input  start_valid,
        input  hit_floor,
        input  hit_ceiling,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/core/gregorian_date_add_days_unit.sv =====
// ============================================================================
// Gregorian date add-days unit
// Shifts a calendar date by a signed number of days, one month per cycle,
// with flooring at 01/01/MIN_YEAR and saturation at 31/12/MAX_YEAR.
// ============================================================================
//
//   Channel  Role    Payload
//   -------  ------  -------------------------------------------------------
//   req      sink    start_day, start_month, start_year, day_offset
//   rsp      source  result_day, result_month, result_year,
//                    start_valid, hit_floor, hit_ceiling
//
// A request is reduced modulo 400 in repeated steps, checked, then walked one
// month at a time toward the target date before its result is registered; the
// sequencer returns to idle before the next request is taken.
// An invalid start date skips the walk and goes straight to the result.
// Reset clears the sequencer and the result register; no clearing pass.
// The next request is taken while a finished result waits on rsp.ready.
//
`default_nettype none

module gregorian_date_add_days_unit
    import gdad_pkg::*;
#(
    parameter int MIN_YEAR    = MIN_YEAR_DEF,
    parameter int MAX_YEAR    = MAX_YEAR_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    gdad_req_if.sink  req,
    gdad_rsp_if.source rsp
);

    localparam int ALU_W = (OFFSET_BITS + 1 > YEAR_IN_W + 2) ? OFFSET_BITS + 1
                                                             : YEAR_IN_W + 2;
    localparam logic [YEAR_W-1:0] MIN_Y = YEAR_W'(MIN_YEAR);
    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                        state_reg,  state_next;
    logic [DAY_W-1:0]              day_reg,    day_next;
    logic [MONTH_W-1:0]            month_reg,  month_next;
    logic [YEAR_W-1:0]             year_reg,   year_next;
    logic [YEAR_IN_W-1:0]          ymod_reg,   ymod_next;
    logic signed [OFFSET_BITS-1:0] off_reg,    off_next;
    logic signed [ALU_W-1:0]       rem_reg,    rem_next;
    logic                          ok_reg,     ok_next;
    logic                          floor_reg,  floor_next;
    logic                          ceil_reg,   ceil_next;

    logic                          out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]              out_day_reg,   out_day_next;
    logic [MONTH_W-1:0]            out_month_reg, out_month_next;
    logic [YEAR_IN_W-1:0]          out_year_reg,  out_year_next;
    logic                          out_ok_reg,    out_ok_next;
    logic                          out_floor_reg, out_floor_next;
    logic                          out_ceil_reg,  out_ceil_next;

    logic signed [ALU_W-1:0]       alu_a;
    logic signed [ALU_W-1:0]       alu_b;
    logic                          alu_sub;
    logic signed [ALU_W-1:0]       alu_sum;
    logic                          alu_neg;

    logic [YMOD_W-1:0]             ymod_cur;
    logic [YMOD_W-1:0]             ymod_prev;
    logic [YMOD_W-1:0]             ymod_succ;
    logic                          leap_cur;
    logic                          leap_prev;
    logic                          at_jan;
    logic                          at_dec;
    logic                          rem_neg;
    logic [MONTH_W-1:0]            month_prev;
    logic [DAY_W-1:0]              dim_cur;
    logic [DAY_W-1:0]              dim_prev;
    logic                          start_ok;

    // Calendar position helpers around the current month.
    assign ymod_cur   = ymod_reg[YMOD_W-1:0];
    assign ymod_prev  = (ymod_cur == '0) ? YMOD_LAST : ymod_cur - YMOD_W'(1);
    assign ymod_succ  = (ymod_cur == YMOD_LAST) ? '0 : ymod_cur + YMOD_W'(1);
    assign at_jan     = (month_reg == MONTH_JAN);
    assign at_dec     = (month_reg == MONTH_DEC);
    assign leap_cur   = is_leap(ymod_cur);
    assign leap_prev  = at_jan ? is_leap(ymod_prev) : leap_cur;
    assign month_prev = at_jan ? MONTH_DEC : month_reg - MONTH_W'(1);
    assign dim_cur    = month_days(month_reg, leap_cur);
    assign dim_prev   = month_days(month_prev, leap_prev);
    assign rem_neg    = rem_reg[ALU_W-1];

    // Start date check, valid once the year has been reduced.
    assign start_ok = (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC) &&
                      (year_reg >= MIN_Y) && (year_reg <= MAX_Y) &&
                      (day_reg != '0) && (day_reg <= dim_cur);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_REDUCE:
            begin
                alu_a   = ALU_W'(ymod_reg);
                alu_b   = ALU_W'(LEAP_CYCLE);
                alu_sub = 1'b1;
            end
            ST_CHECK:
            begin
                alu_a   = ALU_W'(off_reg);
                alu_b   = ALU_W'(day_reg - DAY_W'(1));
                alu_sub = 1'b0;
            end
            ST_WALK:
            begin
                alu_a   = rem_reg;
                alu_b   = rem_neg ? ALU_W'(dim_prev) : ALU_W'(dim_cur);
                alu_sub = ~rem_neg;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    gdad_addsub #(
        .WIDTH (ALU_W)
    ) u_addsub (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_sum),
        .neg    (alu_neg)
    );

    // Sequencer next-state and working registers.
    always_comb
    begin
        state_next     = state_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        ok_next        = ok_reg;
        floor_next     = floor_reg;
        ceil_next      = ceil_reg;
        out_valid_next = out_valid_reg;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_ok_next    = out_ok_reg;
        out_floor_next = out_floor_reg;
        out_ceil_next  = out_ceil_reg;

        // The result register empties when the consumer takes it.
        if (rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    day_next   = req.start_day;
                    month_next = req.start_month;
                    year_next  = YEAR_W'(req.start_year);
                    ymod_next  = req.start_year;
                    off_next   = req.day_offset;
                    floor_next = 1'b0;
                    ceil_next  = 1'b0;
                    state_next = ST_REDUCE;
                end
            end

            // Bring the year down modulo 400 for the leap rule.
            ST_REDUCE:
            begin
                if (alu_neg)
                    state_next = ST_CHECK;
                else
                    ymod_next = alu_sum[YEAR_IN_W-1:0];
            end

            // Validate the start and fold the day into the offset.
            ST_CHECK:
            begin
                ok_next = start_ok;
                if (start_ok)
                begin
                    rem_next   = alu_sum;
                    state_next = ST_WALK;
                end
                else
                begin
                    day_next   = DAY_W'(1);
                    month_next = MONTH_JAN;
                    year_next  = MIN_Y;
                    state_next = ST_DONE;
                end
            end

            // Step one month toward the target date each cycle.
            ST_WALK:
            begin
                if (rem_neg)
                begin
                    if (at_jan && year_reg == MIN_Y)
                    begin
                        floor_next = 1'b1;
                        day_next   = DAY_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next   = alu_sum;
                        month_next = month_prev;
                        if (at_jan)
                        begin
                            year_next = year_reg - YEAR_W'(1);
                            ymod_next = YEAR_IN_W'(ymod_prev);
                        end
                    end
                end
                else if (alu_neg)
                begin
                    day_next   = rem_reg[DAY_W-1:0] + DAY_W'(1);
                    state_next = ST_DONE;
                end
                else if (at_dec && year_reg == MAX_Y)
                begin
                    ceil_next  = 1'b1;
                    day_next   = dim_cur;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next = alu_sum;
                    if (at_dec)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + YEAR_W'(1);
                        ymod_next  = YEAR_IN_W'(ymod_succ);
                    end
                    else
                    begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end
            end

            // Hand the result over once the result register is free.
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_day_next   = day_reg;
                    out_month_next = month_reg;
                    out_year_next  = year_reg[YEAR_IN_W-1:0];
                    out_ok_next    = ok_reg;
                    out_floor_next = floor_reg;
                    out_ceil_next  = ceil_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            ymod_reg      <= '0;
            off_reg       <= '0;
            rem_reg       <= '0;
            ok_reg        <= 1'b0;
            floor_reg     <= 1'b0;
            ceil_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_day_reg   <= '0;
            out_month_reg <= '0;
            out_year_reg  <= '0;
            out_ok_reg    <= 1'b0;
            out_floor_reg <= 1'b0;
            out_ceil_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            ymod_reg      <= ymod_next;
            off_reg       <= off_next;
            rem_reg       <= rem_next;
            ok_reg        <= ok_next;
            floor_reg     <= floor_next;
            ceil_reg      <= ceil_next;
            out_valid_reg <= out_valid_next;
            out_day_reg   <= out_day_next;
            out_month_reg <= out_month_next;
            out_year_reg  <= out_year_next;
            out_ok_reg    <= out_ok_next;
            out_floor_reg <= out_floor_next;
            out_ceil_reg  <= out_ceil_next;
        end
    end

    // Channel outputs.
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_day   = out_day_reg;
    assign rsp.result_month = out_month_reg;
    assign rsp.result_year  = out_year_reg;
    assign rsp.start_valid  = out_ok_reg;
    assign rsp.hit_floor    = out_floor_reg;
    assign rsp.hit_ceiling  = out_ceil_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gdad_addsub.sv =====
// ============================================================================
// Date shifter shared add/subtract unit
// One signed adder with a sign flag; the sequencer uses it for the year
// reduction, the offset setup and every month step.
// ============================================================================
`default_nettype none

module gdad_addsub
    import gdad_pkg::*;
#(
    parameter int WIDTH = YEAR_W
)
(
    input  logic signed [WIDTH-1:0] a,
    input  logic signed [WIDTH-1:0] b,
    input  logic                    sub,
    output logic signed [WIDTH-1:0] result,
    output logic                    neg
);

    // Subtraction is done as addition of the inverted operand plus one.
    logic signed [WIDTH-1:0] b_eff;

    assign b_eff  = sub ? ~b : b;
    assign result = a + b_eff + WIDTH'(sub);
    assign neg    = result[WIDTH-1];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Gregorian date add-days unit testbench
// Feeds start dates and signed day offsets through the request channel and
// checks every result against a calendar predictor kept in the testbench.
// A directed set covers the range limits, leap rules and invalid dates.
// Random requests follow, most of them valid dates with short offsets and a
// few with full-width offsets, under changing sender and receiver pacing.
// ============================================================================

module tb;
    import gdad_pkg::*;

    localparam int FIRST_YEAR    = MIN_YEAR_DEF;
    localparam int LAST_YEAR     = MAX_YEAR_DEF;
    localparam int RANDOM_COUNT  = 76;
    localparam int QUIET_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 200;
    localparam int BUSY_PCT      = 67;
    localparam int LIGHT_PCT     = 10;

    typedef enum logic [1:0] {
        PHASE_STEADY,
        PHASE_SENDER_IDLE,
        PHASE_SINK_STALL,
        PHASE_BOTH
    } traffic_phase_t;

    typedef struct {
        logic [DAY_W-1:0]                  day;
        logic [MONTH_W-1:0]                month;
        logic [YEAR_IN_W-1:0]              year;
        logic signed [OFFSET_BITS_DEF-1:0] offset;
    } date_request_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_IN_W-1:0] year;
        logic                 start_valid;
        logic                 hit_floor;
        logic                 hit_ceiling;
    } shifted_date_t;

    logic clk;
    logic rst_n;

    gdad_req_if #(.OFFSET_BITS(OFFSET_BITS_DEF)) req_ch ();
    gdad_rsp_if rsp_ch ();

    gregorian_date_add_days_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    date_request_t  pending_requests [$];
    shifted_date_t  expected_dates [$];
    date_request_t  next_request;
    traffic_phase_t traffic_phase;
    int             sender_idle_pct;
    int             sink_stall_pct;
    int             request_total  = 0;
    int             issued_count   = 0;
    int             accepted_count = 0;
    int             failures       = 0;
    int             quiet_cycles   = 0;

    // Gregorian leap rule: every fourth year, centuries only every 400 years.
    function automatic bit leap_year(input longint y);
        if (y % 100 == 0)
            return (y % 400 == 0);
        return (y % 4 == 0);
    endfunction

    function automatic longint month_length(input longint m, input longint y);
        if (m == MONTH_FEB && leap_year(y))
            return longint'(DAYS_FEB_LEAP);
        return longint'(MONTH_LEN[4'(m - 1)]);
    endfunction

    // Days from the first day of year 1 to the first day of year y.
    function automatic longint days_before_year(input longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // Expected result of shifting a start date by a signed number of days.
    function automatic shifted_date_t shift_date(
        input logic [DAY_W-1:0]                  d_in,
        input logic [MONTH_W-1:0]                m_in,
        input logic [YEAR_IN_W-1:0]              y_in,
        input logic signed [OFFSET_BITS_DEF-1:0] off_in
    );
        longint        d, m, y, off, epoch, last_day, n, ry, rm;
        shifted_date_t r;
        d   = longint'(d_in);
        m   = longint'(m_in);
        y   = longint'(y_in);
        off = longint'(off_in);
        r.day         = 5'd1;
        r.month       = MONTH_JAN;
        r.year        = YEAR_IN_W'(FIRST_YEAR);
        r.start_valid = 1'b0;
        r.hit_floor   = 1'b0;
        r.hit_ceiling = 1'b0;
        if (m < 1 || m > 12 || y < FIRST_YEAR || y > LAST_YEAR)
            return r;
        if (d < 1 || d > month_length(m, y))
            return r;
        r.start_valid = 1'b1;

        // Day index counted from the first day of the range.
        epoch    = days_before_year(FIRST_YEAR);
        last_day = days_before_year(LAST_YEAR + 1) - epoch - 1;
        n = days_before_year(y) - epoch;
        for (rm = 1; rm < m; rm++)
            n += month_length(rm, y);
        n += d - 1 + off;
        if (n < 0) begin
            n = 0;
            r.hit_floor = 1'b1;
        end
        else if (n > last_day) begin
            n = last_day;
            r.hit_ceiling = 1'b1;
        end

        // Convert the index back into a calendar date.
        ry = FIRST_YEAR + n / 366;
        while (days_before_year(ry + 1) - epoch <= n)
            ry++;
        n -= days_before_year(ry) - epoch;
        rm = 1;
        while (rm < 12 && n >= month_length(rm, ry)) begin
            n -= month_length(rm, ry);
            rm++;
        end
        r.day   = DAY_W'(n + 1);
        r.month = MONTH_W'(rm);
        r.year  = YEAR_IN_W'(ry);
        return r;
    endfunction

    task automatic add_request(input int d, input int m, input int y, input int off);
        date_request_t item;
        item.day    = DAY_W'(d);
        item.month  = MONTH_W'(m);
        item.year   = YEAR_IN_W'(y);
        item.offset = OFFSET_BITS_DEF'(off);
        pending_requests.push_back(item);
    endtask

    task automatic report_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            failures++;
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Pacing follows the share of requests already issued.
    always_comb
    begin
        if (issued_count * 4 < request_total)
            traffic_phase = PHASE_STEADY;
        else if (issued_count * 2 < request_total)
            traffic_phase = PHASE_SENDER_IDLE;
        else if (issued_count * 4 < request_total * 3)
            traffic_phase = PHASE_SINK_STALL;
        else
            traffic_phase = PHASE_BOTH;
        case (traffic_phase)
            PHASE_SENDER_IDLE: begin sender_idle_pct = BUSY_PCT;  sink_stall_pct = 0;         end
            PHASE_SINK_STALL:  begin sender_idle_pct = 0;         sink_stall_pct = BUSY_PCT;  end
            PHASE_BOTH:        begin sender_idle_pct = LIGHT_PCT; sink_stall_pct = LIGHT_PCT; end
            default:           begin sender_idle_pct = 0;         sink_stall_pct = 0;         end
        endcase
    end

    // Request driver: predicts each accepted request and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.start_day   <= '0;
            req_ch.start_month <= '0;
            req_ch.start_year  <= '0;
            req_ch.day_offset  <= '0;
        end
        else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_dates.push_back(shift_date(req_ch.start_day, req_ch.start_month,
                                                    req_ch.start_year, req_ch.day_offset));
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.start_day   <= next_request.day;
                    req_ch.start_month <= next_request.month;
                    req_ch.start_year  <= next_request.year;
                    req_ch.day_offset  <= next_request.offset;
                    issued_count++;
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker: each result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: result with no request outstanding, got %0d/%0d/%0d",
                         $time, rsp_ch.result_day, rsp_ch.result_month, rsp_ch.result_year);
                failures++;
            end
            else begin
                report_field("result_day",   expected_dates[0].day,   rsp_ch.result_day);
                report_field("result_month", expected_dates[0].month, rsp_ch.result_month);
                report_field("result_year",  expected_dates[0].year,  rsp_ch.result_year);
                report_field("start_valid",  expected_dates[0].start_valid, rsp_ch.start_valid);
                report_field("hit_floor",    expected_dates[0].hit_floor,   rsp_ch.hit_floor);
                report_field("hit_ceiling",  expected_dates[0].hit_ceiling, rsp_ch.hit_ceiling);
                void'(expected_dates.pop_front());
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int kind;
        int m;
        int y;
        int off;
        rst_n = 1'b0;

        // Range limits: exact landings and clamps on both ends.
        add_request(1, 1, 1900, 0);
        add_request(1, 1, 1900, -1);
        add_request(2, 1, 1900, -1);
        add_request(31, 12, 9999, 0);
        add_request(31, 12, 9999, 1);
        add_request(30, 12, 9999, 1);
        // Leap rules and month and year rollover.
        add_request(29, 2, 2000, 0);
        add_request(29, 2, 1900, 5);
        add_request(29, 2, 2024, 366);
        add_request(29, 2, 2023, 0);
        add_request(28, 2, 2100, 1);
        add_request(31, 12, 1999, 1);
        // Invalid start dates of every kind.
        add_request(0, 6, 2000, 10);
        add_request(31, 4, 2000, 0);
        add_request(15, 0, 2000, 0);
        add_request(15, 13, 2000, 0);
        add_request(15, 15, 2000, 0);
        add_request(31, 12, 1899, 1);
        add_request(1, 1, 10000, -1);
        add_request(31, 15, 16383, -1);
        // Full-width offsets, with and without clamping.
        add_request(1, 1, 1900, 1048575);
        add_request(31, 12, 9999, -1048576);
        add_request(1, 1, 2000, -1048576);
        add_request(1, 1, 9000, 1048575);

        // Random requests, mostly valid dates with short offsets.
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            kind = $urandom_range(99);
            off  = int'($urandom_range(4000)) - 2000;
            if (kind < 80) begin
                if (kind < 8)
                    y = (kind < 4) ? $urandom_range(1905, 1900) : $urandom_range(9999, 9994);
                else
                    y = $urandom_range(LAST_YEAR, FIRST_YEAR);
                m = $urandom_range(12, 1);
                if ($urandom_range(99) < 4)
                    off = $urandom;
                add_request($urandom_range(month_length(m, y), 1), m, y, off);
            end
            else begin
                add_request($urandom_range(31), $urandom_range(15), $urandom_range(16383), off);
            end
        end
        request_total = pending_requests.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < request_total || expected_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
